>>> rtl/mdpe_pkg.sv
// shared types and marker constants for the marker delimited payload extractor
package mdpe_pkg;

    localparam int MARK_LEN = 17;
    localparam int FILL_W   = $clog2(MARK_LEN + 1);

    // start marker, oldest byte first
    localparam logic [7:0] START_MARK [MARK_LEN] = '{
        8'h79, 8'h79, 8'h65, 8'h66, 8'h66, 8'h65, 8'h63, 8'h74, 8'h6d,
        8'h70, 8'h34, 8'h6a, 8'h73, 8'h6f, 8'h6e, 8'h5b, 8'h5b
    };

    // end marker, oldest byte first
    localparam logic [7:0] END_MARK [MARK_LEN] = '{
        8'h5d, 8'h5d, 8'h79, 8'h79, 8'h65, 8'h66, 8'h66, 8'h65, 8'h63,
        8'h74, 8'h6d, 8'h70, 8'h34, 8'h6a, 8'h73, 8'h6f, 8'h6e
    };

    typedef enum logic [1:0] {
        PH_SEARCH  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    // one input transfer as held in the input register
    typedef struct packed {
        logic [7:0] in_byte;
        logic       first;
        logic       last;
    } item_t;

    // one result transfer
    typedef struct packed {
        logic       has_byte;
        logic [7:0] payload_byte;
        logic       done_res;
        logic       found;
    } res_t;

endpackage

>>> rtl/marker_delimited_payload_extractor_core.sv
// top level of the marker delimited payload extractor
// Takes one file byte per transfer and, once the 17-byte start marker has
// been seen, passes payload bytes out 17 bytes late through a window that
// watches for the 17-byte end marker; the search ends with done_res set and
// found telling whether the end marker arrived by the last byte. A byte
// with first set restarts the search. One byte is accepted every cycle while
// the output is not stalled; each result passes through the input register
// and the result register, which hold the window shift and both marker
// compares between them. Bytes that give no result (marker search, window
// filling, after the end) produce no output transfer.
module marker_delimited_payload_extractor_core
    import mdpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       first,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       has_byte,
    output logic [7:0] payload_byte,
    output logic       done_res,
    output logic       found
);

    logic  s1_valid;
    item_t s1_item;
    logic  s1_take;
    res_t  res;

    // input register
    mdpe_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .first    (first),
        .last     (last),
        .in_stall (in_stall),
        .s1_valid (s1_valid),
        .s1_item  (s1_item),
        .s1_take  (s1_take)
    );

    // search logic and result register
    mdpe_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_item   (s1_item),
        .s1_take   (s1_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign has_byte     = res.has_byte;
    assign payload_byte = res.payload_byte;
    assign done_res     = res.done_res;
    assign found        = res.found;

    // every result carries a byte or an end of search
    a_res_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (has_byte || done_res))
        else $error("result with neither byte nor done");

    // found only comes with the end of search
    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> done_res)
        else $error("found without done_res");

    // no stray data when no byte is carried
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_byte) |-> (payload_byte == 8'h00))
        else $error("payload_byte set without has_byte");

endmodule

>>> rtl/mdpe_in_stage.sv
// input register stage of the marker delimited payload extractor
module mdpe_in_stage
    import mdpe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  [7:0] in_byte,
    input  logic  first,
    input  logic  last,
    output logic  in_stall,
    output logic  s1_valid,
    output item_t s1_item,
    input  logic  s1_take
);

    logic  s1_valid_reg;
    logic  s1_valid_next;
    item_t s1_item_reg;
    logic  accept;

    // stall only when a held item is not moving on this cycle
    assign in_stall = s1_valid_reg && !s1_take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_take)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= '{in_byte: in_byte, first: first, last: last};
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;

endmodule

>>> rtl/mdpe_scan.sv
// marker search, delay window and result register
module mdpe_scan
    import mdpe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s1_valid,
    input  item_t s1_item,
    output logic  s1_take,
    output logic  out_valid,
    input  logic  out_stall,
    output res_t  res
);

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [7:0]        win_reg  [MARK_LEN];
    logic [7:0]        win_next [MARK_LEN];
    logic              out_valid_reg;
    logic              out_valid_next;
    res_t              res_reg;
    res_t              res_next;

    phase_t            phase_eff;
    logic [FILL_W-1:0] fill_eff;
    logic              out_free;
    logic              full_new;
    logic              start_hit;
    logic              end_hit;
    logic              produce;

    // result register free to load
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_take  = s1_valid && out_free;

    // restart clears phase and fill before the byte is looked at
    assign phase_eff = s1_item.first ? PH_SEARCH : phase_reg;
    assign fill_eff  = s1_item.first ? '0 : fill_reg;

    // shifted window, newest byte at the top
    always_comb
    begin
        for (int i = 0; i < MARK_LEN - 1; i++)
        begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[MARK_LEN - 1] = s1_item.in_byte;
    end

    assign full_new = (fill_eff >= FILL_W'(MARK_LEN - 1));

    // constant compares against both markers
    always_comb
    begin
        start_hit = full_new;
        end_hit   = full_new;
        for (int i = 0; i < MARK_LEN; i++)
        begin
            if (win_next[i] != START_MARK[i])
            begin
                start_hit = 1'b0;
            end
            if (win_next[i] != END_MARK[i])
            begin
                end_hit = 1'b0;
            end
        end
    end

    // next phase, fill count and result
    always_comb
    begin
        phase_next = phase_reg;
        fill_next  = fill_reg;
        res_next   = '0;
        if (s1_take)
        begin
            phase_next = phase_eff;
            fill_next  = full_new ? FILL_W'(MARK_LEN) : fill_eff + 1'b1;
            case (phase_eff)
                PH_SEARCH:
                begin
                    if (start_hit)
                    begin
                        phase_next = PH_PAYLOAD;
                        fill_next  = '0;
                    end
                    if (s1_item.last)
                    begin
                        phase_next        = PH_DONE;
                        res_next.done_res = 1'b1;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (fill_eff == FILL_W'(MARK_LEN))
                    begin
                        res_next.has_byte     = 1'b1;
                        res_next.payload_byte = win_reg[0];
                    end
                    if (end_hit)
                    begin
                        phase_next        = PH_DONE;
                        res_next.done_res = 1'b1;
                        res_next.found    = 1'b1;
                    end
                    else if (s1_item.last)
                    begin
                        phase_next        = PH_DONE;
                        res_next.done_res = 1'b1;
                    end
                end
                default:
                begin
                    // finished: byte dropped, state kept
                    phase_next = phase_eff;
                    fill_next  = fill_eff;
                end
            endcase
        end
    end

    assign produce = res_next.has_byte || res_next.done_res;

    // result register valid
    always_comb
    begin
        if (out_free)
        begin
            out_valid_next = s1_take && produce;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SEARCH;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // window shifts on every transfer that is not ignored
    always_ff @(posedge clk)
    begin
        if (s1_take && (phase_eff == PH_SEARCH || phase_eff == PH_PAYLOAD))
        begin
            win_reg <= win_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_free && s1_take && produce)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

>>> dv/tb_top.sv
// testbench for the marker delimited payload extractor: stimulus, prediction and result checks
module tb_top
    import mdpe_pkg::*;
();

    localparam int RANDOM_ITEMS = 680;
    localparam int CALM_TAIL    = 150;
    localparam int HOLD_LEN     = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_LIMIT  = 1000;
    localparam int SETTLE       = 6;

    // predicts the result of each accepted file byte and checks what the block returns
    class extraction_board;
        phase_t     ph;
        logic [7:0] win [MARK_LEN];
        int         fill;
        res_t       due_results [$];
        int         errors;
        int         live_bytes;
        int         results_seen;
        int         payload_seen;
        int         found_seen;
        int         missing_seen;

        function new();
            errors       = 0;
            live_bytes   = 0;
            results_seen = 0;
            payload_seen = 0;
            found_seen   = 0;
            missing_seen = 0;
            ph           = PH_SEARCH;
            clear_window();
        endfunction

        function void clear_window();
            for (int i = 0; i < MARK_LEN; i++)
                win[i] = 8'h00;
            fill = 0;
        endfunction

        function bit window_holds(logic [7:0] mark [MARK_LEN]);
            if (fill < MARK_LEN)
                return 1'b0;
            for (int i = 0; i < MARK_LEN; i++)
                if (win[i] !== mark[i])
                    return 1'b0;
            return 1'b1;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // one accepted file byte
        function void predict_byte(logic [7:0] b, logic is_first, logic is_last);
            logic [7:0] oldest;
            bit         spill;
            res_t       r;
            if (is_first)
            begin
                ph = PH_SEARCH;
                clear_window();
            end
            // after the end of a search only a new file wakes the block
            if (ph != PH_SEARCH && ph != PH_PAYLOAD)
                return;
            live_bytes++;
            oldest = win[0];
            spill  = (fill >= MARK_LEN);
            for (int i = 0; i < MARK_LEN - 1; i++)
                win[i] = win[i + 1];
            win[MARK_LEN - 1] = b;
            if (fill < MARK_LEN)
                fill++;
            r = '0;
            if (ph == PH_SEARCH)
            begin
                if (window_holds(START_MARK))
                begin
                    ph = PH_PAYLOAD;
                    clear_window();
                end
                if (is_last)
                begin
                    ph = PH_DONE;
                    r.done_res = 1'b1;
                end
            end
            else
            begin
                if (spill)
                begin
                    r.has_byte     = 1'b1;
                    r.payload_byte = oldest;
                end
                if (window_holds(END_MARK))
                begin
                    ph = PH_DONE;
                    r.done_res = 1'b1;
                    r.found    = 1'b1;
                end
                else if (is_last)
                begin
                    ph = PH_DONE;
                    r.done_res = 1'b1;
                end
            end
            if (r.has_byte || r.done_res)
                due_results.push_back(r);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        // one accepted result transfer
        task check_result(res_t got);
            res_t want;
            results_seen++;
            if (due_results.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing due: %h",
                                 results_seen, got));
                return;
            end
            want = due_results.pop_front();
            if (got.has_byte !== want.has_byte)
                report($sformatf("result %0d has_byte %b, want %b",
                                 results_seen, got.has_byte, want.has_byte));
            if (got.payload_byte !== want.payload_byte)
                report($sformatf("result %0d payload_byte %h, want %h",
                                 results_seen, got.payload_byte, want.payload_byte));
            if (got.done_res !== want.done_res)
                report($sformatf("result %0d done_res %b, want %b",
                                 results_seen, got.done_res, want.done_res));
            if (got.found !== want.found)
                report($sformatf("result %0d found %b, want %b",
                                 results_seen, got.found, want.found));
            if (want.has_byte)
                payload_seen++;
            if (want.done_res && want.found)
                found_seen++;
            else if (want.done_res)
                missing_seen++;
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       first;
    logic       last;
    logic       out_valid;
    logic       out_stall;
    logic       has_byte;
    logic [7:0] payload_byte;
    logic       done_res;
    logic       found;

    extraction_board board;
    logic [7:0]      file_q [$];
    bit              tx_idle_on;
    bit              rx_idle_on;
    bit              hold_req;
    int              files_sent;
    res_t            seen;

    marker_delimited_payload_extractor_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .first        (first),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .has_byte     (has_byte),
        .payload_byte (payload_byte),
        .done_res     (done_res),
        .found        (found)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // offer one byte, with an optional idle burst before it, and wait for the transfer
    task automatic send_byte(input logic [7:0] b, input logic is_first, input logic is_last);
        int gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= b;
        first    <= is_first;
        last     <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.predict_byte(b, is_first, is_last);
    endtask

    // send the bytes built up in file_q as one file
    task automatic send_file(input bit set_last);
        for (int i = 0; i < file_q.size(); i++)
            send_byte(file_q[i], i == 0, set_last && i == file_q.size() - 1);
        files_sent++;
    endtask

    task automatic push_mark(input bit is_end, input int count);
        for (int i = 0; i < count; i++)
            file_q.push_back(is_end ? END_MARK[i] : START_MARK[i]);
    endtask

    task automatic push_random(input int count);
        repeat (count)
            file_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // stop offering and wait until every due result has come back
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && board.pending() != 0; n++)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    // one random file: mostly well formed, some cut short, some loose noise
    task automatic random_file();
        int kind;
        int plen;
        kind   = $urandom_range(0, 9);
        file_q = {};
        push_random($urandom_range(0, 4));
        if (kind < 7)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                push_mark(1'b0, $urandom_range(1, MARK_LEN - 1));
                push_random(1);
            end
            push_mark(1'b0, MARK_LEN);
            plen = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(0, 30);
            push_random(plen);
            if ($urandom_range(0, 5) == 0)
            begin
                push_mark(1'b1, $urandom_range(1, MARK_LEN - 1));
                push_random(1);
            end
            if ($urandom_range(0, 4) != 0)
                push_mark(1'b1, MARK_LEN);
            push_random($urandom_range(0, 3));
            send_file(1'b1);
        end
        else if (kind < 9)
        begin
            // cut short: no last byte, the next file restarts the search
            push_mark(1'b0, $urandom_range(1, MARK_LEN));
            push_random($urandom_range(0, 25));
            send_file(1'b0);
        end
        else
        begin
            repeat ($urandom_range(1, 20))
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                          $urandom_range(0, 7) == 0);
        end
    endtask

    // result side: random stall bursts and one long hold-off on request
    initial
    begin
        int burst;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_LEN - 1)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
            else if (rx_idle_on && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 17);
                out_stall <= 1'b1;
                repeat (burst - 1)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
            else
                out_stall <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen.has_byte     = has_byte;
            seen.payload_byte = payload_byte;
            seen.done_res     = done_res;
            seen.found        = found;
            board.check_result(seen);
        end
    end

    // watchdog on cycles with no transfer on either side
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, board.pending());
        $display("FAIL");
        $finish;
    end

    // main sequence
    initial
    begin
        int  base;
        bit  pressure_done;
        board         = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_byte       = 8'h00;
        first         = 1'b0;
        last          = 1'b0;
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b0;
        hold_req      = 1'b0;
        files_sent    = 0;
        pressure_done = 1'b0;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single byte file, both flags on one byte
        file_q = {8'h00};
        send_file(1'b1);
        // start marker at the very first byte and ending the file
        file_q = {};
        push_mark(1'b0, MARK_LEN);
        send_file(1'b1);
        // empty payload
        file_q = {};
        push_mark(1'b0, MARK_LEN);
        push_mark(1'b1, MARK_LEN);
        send_file(1'b1);
        // end marker pushes out the last payload byte; trailing byte ignored
        file_q = {};
        push_mark(1'b0, MARK_LEN);
        file_q.push_back(8'h00);
        file_q.push_back(8'hff);
        push_mark(1'b1, MARK_LEN);
        file_q.push_back(8'haa);
        send_file(1'b1);
        // loose bytes after the end of a search, without first
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        // end marker before the start marker, then end of file inside payload
        file_q = {};
        push_mark(1'b1, MARK_LEN);
        push_mark(1'b0, MARK_LEN);
        for (int i = 0; i < 20; i++)
            file_q.push_back(i[0] ? 8'hff : 8'h00);
        send_file(1'b1);
        // restart in the middle of a payload
        file_q = {};
        push_mark(1'b0, MARK_LEN);
        push_random(3);
        send_file(1'b0);
        file_q = {};
        push_mark(1'b0, MARK_LEN);
        push_random(18);
        push_mark(1'b1, MARK_LEN);
        send_file(1'b1);
        wait_drain();

        // random files
        base = board.live_bytes;
        while (board.live_bytes - base < RANDOM_ITEMS)
        begin
            if (board.live_bytes - base >= RANDOM_ITEMS - CALM_TAIL)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            else
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            if (!pressure_done && board.live_bytes - base >= 300)
            begin
                // long output hold-off while a long payload keeps coming
                tx_idle_on = 1'b0;
                hold_req   = 1'b1;
                file_q = {};
                push_mark(1'b0, MARK_LEN);
                push_random(70);
                push_mark(1'b1, MARK_LEN);
                send_file(1'b1);
                wait_drain();
                pressure_done = 1'b1;
            end
            else
                random_file();
        end

        wait_drain();
        if (board.pending() != 0)
            board.report($sformatf("%0d results never arrived", board.pending()));
        $display("covered %0d files and %0d live bytes: %0d payload bytes, %0d found, %0d %s",
                 files_sent, board.live_bytes, board.payload_seen, board.found_seen,
                 board.missing_seen, "not found");
        $display("included an output hold-off of %0d cycles and drain pauses; %0d mismatches",
                 HOLD_LEN, board.errors);
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
